// ===== sv/sk128_pkg.sv =====
// Shared types, constants and S-box functions for the SKINNY-128 cipher block.
// No dependencies; imported by sk128_round and skinny128_block_cipher.
`default_nettype none

package sk128_pkg;

    localparam int MAX_ROUNDS = 56;
    localparam int KEY_IDX_W  = $clog2(MAX_ROUNDS);
    localparam int CNT_W      = $clog2(MAX_ROUNDS + 1);
    localparam int RC_W       = 6;

    localparam logic [RC_W-1:0] ROUND_COUNT_RESET = 6'd40;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ENC  = 2'd1,
        OP_DEC  = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    // Bit-sliced 8-bit S-box applied to the four cells of one row.
    function automatic logic [31:0] sbox_word(input logic [31:0] xi);
        logic [31:0] x;
        logic [31:0] y;
        x = xi;
        x = x ^ ((~((x >> 2) | (x >> 3))) & 32'h11111111);
        y = (~((x << 5) | (x << 1))) & 32'h20202020;
        x = x ^ (((~((x << 5) | (x << 4))) & 32'h40404040) ^ y);
        y = (~((x << 2) | (x << 1))) & 32'h80808080;
        x = x ^ (((~((x >> 2) | (x << 1))) & 32'h02020202) ^ y);
        y = (~((x >> 5) | (x << 1))) & 32'h04040404;
        x = x ^ (((~((x >> 1) | (x >> 2))) & 32'h08080808) ^ y);
        return ((x & 32'h08080808) << 1) | ((x & 32'h32323232) << 2) |
               ((x & 32'h01010101) << 5) | ((x & 32'h80808080) >> 6) |
               ((x & 32'h40404040) >> 4) | ((x & 32'h04040404) >> 2);
    endfunction

    function automatic logic [31:0] inv_sbox_word(input logic [31:0] xi);
        logic [31:0] x;
        logic [31:0] y;
        x = xi;
        y = (~((x >> 1) | (x >> 3))) & 32'h01010101;
        x = x ^ (((~((x >> 2) | (x >> 3))) & 32'h10101010) ^ y);
        y = (~((x >> 6) | (x >> 1))) & 32'h02020202;
        x = x ^ (((~((x >> 1) | (x >> 2))) & 32'h08080808) ^ y);
        y = (~((x << 2) | (x << 1))) & 32'h80808080;
        x = x ^ (((~((x >> 1) | (x << 2))) & 32'h04040404) ^ y);
        y = (~((x << 5) | (x << 1))) & 32'h20202020;
        x = x ^ (((~((x << 4) | (x << 5))) & 32'h40404040) ^ y);
        return ((x & 32'h01010101) << 2) | ((x & 32'h04040404) << 4) |
               ((x & 32'h02020202) << 6) | ((x & 32'h20202020) >> 5) |
               ((x & 32'hC8C8C8C8) >> 2) | ((x & 32'h10101010) >> 1);
    endfunction

endpackage

`default_nettype wire

// ===== sv/sk128_round.sv =====
// One SKINNY-128 round, forward or inverse, on a 128-bit state.
// Depends on sk128_pkg for the S-box functions.
`default_nettype none

module sk128_round (
    input  wire logic [127:0] i_blk,
    input  wire logic [63:0]  i_key,
    input  wire logic         i_dec,
    output logic      [127:0] o_blk
);
    import sk128_pkg::*;

    logic [31:0] r0, r1, r2, r3;
    logic [31:0] k0, k1;
    logic [31:0] e0, e1, e2, e3, et;
    logic [31:0] d0, d1, d2, d3;
    logic [127:0] w_enc, w_dec;

    assign r0 = i_blk[31:0];
    assign r1 = i_blk[63:32];
    assign r2 = i_blk[95:64];
    assign r3 = i_blk[127:96];
    assign k0 = i_key[31:0];
    assign k1 = i_key[63:32];

    always_comb begin
        e0 = sbox_word(r0) ^ k0;
        e1 = sbox_word(r1) ^ k1;
        e2 = sbox_word(r2) ^ 32'h00000002;
        e3 = sbox_word(r3);
        e1 = {e1[23:0], e1[31:24]};
        e2 = {e2[15:0], e2[31:16]};
        e3 = {e3[7:0],  e3[31:8]};
        e1 = e1 ^ e2;
        e2 = e2 ^ e0;
        et = e3 ^ e2;
        w_enc = {e2, e1, e0, et};
    end

    // Inverse mix columns, inverse row shifts, key removal, inverse S-box.
    always_comb begin
        d3 = r0 ^ r3;
        d0 = r1;
        d2 = r3 ^ r1;
        d1 = r2 ^ d2;
        d1 = {d1[7:0],  d1[31:8]};
        d2 = {d2[15:0], d2[31:16]};
        d3 = {d3[23:0], d3[31:24]};
        d0 = inv_sbox_word(d0 ^ k0);
        d1 = inv_sbox_word(d1 ^ k1);
        d2 = inv_sbox_word(d2 ^ 32'h00000002);
        d3 = inv_sbox_word(d3);
        w_dec = {d3, d2, d1, d0};
    end

    assign o_blk = i_dec ? w_dec : w_enc;

endmodule

`default_nettype wire

// ===== sv/skinny128_block_cipher.sv =====
// Top level of the SKINNY-128 cipher block: round-key memory, sequencer, state register.
// Depends on sk128_pkg and sk128_round.
//
//   channel  direction  handshake                  payload
//   in       to block   i_in_valid / o_in_stall    opcode, key_round, key rows, data
//   out      from block o_out_valid / i_out_stall  result_low, result_high
//   cfg      to block   i_cfg_we                   i_cfg_wdata (round_count)
//
// A key load is written to the key memory when it is accepted. An encrypt or decrypt request
// reads its first round key in the cycle it is accepted, then runs one round per pass through
// the shared round unit (round_count, capped at 56), and the finished block then moves into
// the output register; the next request is accepted only after that move.
// The input stalls while a request is in progress, and also while a finished block
// waits for the output register to be taken.
// Reset is synchronous, active low; round_count resets to 40 and the key memory
// holds no defined contents until loaded.
`default_nettype none

module skinny128_block_cipher (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [sk128_pkg::RC_W-1:0]   i_cfg_wdata,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [1:0]                   i_opcode,
    input  wire logic [5:0]                   i_key_round,
    input  wire logic [31:0]                  i_key_row_zero,
    input  wire logic [31:0]                  i_key_row_one,
    input  wire logic [63:0]                  i_data_low,
    input  wire logic [63:0]                  i_data_high,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [63:0]                  o_result_low,
    output logic      [63:0]                  o_result_high
);
    import sk128_pkg::*;

    t_state                r_state, n_state;
    logic [RC_W-1:0]       r_round_count;
    logic [127:0]          r_blk, n_blk;
    logic [CNT_W-1:0]      r_left, n_left;
    logic [KEY_IDX_W-1:0]  r_idx, n_idx;
    logic                  r_dec, n_dec;
    logic [63:0]           r_key;
    logic                  r_out_valid;
    logic [127:0]          r_out;

    logic [63:0]           mem [0:MAX_ROUNDS-1];
    logic                  w_rd_en;
    logic [KEY_IDX_W-1:0]  w_rd_addr;
    logic                  w_wr_en;
    logic [CNT_W-1:0]      w_rounds;
    logic                  w_accept;
    logic                  w_out_take;
    logic                  w_out_load;
    logic [127:0]          w_round_out;
    t_opcode               w_op;

    assign w_op       = t_opcode'(i_opcode);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;
    assign w_rounds   = (32'(r_round_count) > MAX_ROUNDS) ? CNT_W'(MAX_ROUNDS)
                                                         : CNT_W'(r_round_count);
    assign w_wr_en    = w_accept && (w_op == OP_LOAD) && (32'(i_key_round) < MAX_ROUNDS);

    sk128_round u_round (
        .i_blk (r_blk),
        .i_key (r_key),
        .i_dec (r_dec),
        .o_blk (w_round_out)
    );

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[KEY_IDX_W'(i_key_round)] <= {i_key_row_one, i_key_row_zero};
        end
        if (w_rd_en) begin
            r_key <= mem[w_rd_addr];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_blk      = r_blk;
        n_left     = r_left;
        n_idx      = r_idx;
        n_dec      = r_dec;
        w_rd_en    = 1'b0;
        w_rd_addr  = r_idx;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_op == OP_ENC || w_op == OP_DEC)) begin
                    n_blk  = {i_data_high, i_data_low};
                    n_dec  = (w_op == OP_DEC);
                    n_left = w_rounds;
                    n_idx  = (w_op == OP_DEC) ? KEY_IDX_W'(w_rounds - CNT_W'(1))
                                              : '0;
                    if (w_rounds == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = n_idx;
                        n_state   = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                // r_key holds the key for r_idx; fetch the next one meanwhile.
                n_blk  = w_round_out;
                n_left = r_left - CNT_W'(1);
                n_idx  = r_dec ? (r_idx - KEY_IDX_W'(1)) : (r_idx + KEY_IDX_W'(1));
                if (r_left == CNT_W'(1)) begin
                    n_state = ST_DONE;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = n_idx;
                end
            end
            ST_DONE: begin
                // The finished block moves on once the output register is free.
                if (!r_out_valid || w_out_take) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_round_count <= ROUND_COUNT_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_round_count <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk  <= n_blk;
        r_left <= n_left;
        r_idx  <= n_idx;
        r_dec  <= n_dec;
        if (w_out_load) begin
            r_out <= r_blk;
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_result_low  = r_out[63:0];
    assign o_result_high = r_out[127:64];

endmodule

`default_nettype wire

// ===== tb/sv/skinny128_block_cipher_test.sv =====
// Self-checking testbench for skinny128_block_cipher: key loads, encrypt and decrypt requests
// are checked against a predictor of the SKINNY-128 rounds. Depends on sk128_pkg and the block.
module skinny128_block_cipher_test;
    import sk128_pkg::*;

    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int MAX_REPORTS   = 10;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_block;

    logic            i_clk          = 1'b0;
    logic            i_rst_n        = 1'b0;
    logic            i_cfg_we       = 1'b0;
    logic [RC_W-1:0] i_cfg_wdata    = ROUND_COUNT_RESET;
    logic            i_in_valid     = 1'b0;
    logic            o_in_stall;
    logic [1:0]      i_opcode       = OP_NONE;
    logic [5:0]      i_key_round    = '0;
    logic [31:0]     i_key_row_zero = '0;
    logic [31:0]     i_key_row_one  = '0;
    logic [63:0]     i_data_low     = '0;
    logic [63:0]     i_data_high    = '0;
    logic            o_out_valid;
    logic            i_out_stall    = 1'b0;
    logic [63:0]     o_result_low;
    logic [63:0]     o_result_high;

    skinny128_block_cipher uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_key_round    (i_key_round),
        .i_key_row_zero (i_key_row_zero),
        .i_key_row_one  (i_key_row_one),
        .i_data_low     (i_data_low),
        .i_data_high    (i_data_high),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_low   (o_result_low),
        .o_result_high  (o_result_high)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: our own copy of the round keys and the round count.
    logic [63:0]     round_keys [MAX_ROUNDS];
    logic [RC_W-1:0] rounds_cfg = ROUND_COUNT_RESET;
    t_block          expected_blocks [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int unsigned hold_request = 0;
    logic out_hold = 1'b0;

    int fail_count       = 0;
    int blocks_checked   = 0;
    int enc_sent         = 0;
    int dec_sent         = 0;
    int loads_sent       = 0;
    int ignored_sent     = 0;
    int settings_written = 0;

    logic [RC_W-1:0] sweep_counts [12] = '{6'd40, 6'd48, 6'd56, 6'd1, 6'd63, 6'd0,
                                           6'd2, 6'd57, 6'd40, 6'd17, 6'd56, 6'd48};
    int sweep_pos = 0;

    function automatic logic [31:0] rotl32(input logic [31:0] w, input int n);
        return (w << n) | (w >> (32 - n));
    endfunction

    function automatic logic [31:0] sub_cells(input logic [31:0] w);
        logic [31:0] v;
        logic [31:0] s;
        v = w;
        v = v ^ ((~((v >> 2) | (v >> 3))) & 32'h11111111);
        s = (~((v << 5) | (v << 1))) & 32'h20202020;
        v = v ^ (((~((v << 5) | (v << 4))) & 32'h40404040) ^ s);
        s = (~((v << 2) | (v << 1))) & 32'h80808080;
        v = v ^ (((~((v >> 2) | (v << 1))) & 32'h02020202) ^ s);
        s = (~((v >> 5) | (v << 1))) & 32'h04040404;
        v = v ^ (((~((v >> 1) | (v >> 2))) & 32'h08080808) ^ s);
        return ((v & 32'h08080808) << 1) | ((v & 32'h32323232) << 2) |
               ((v & 32'h01010101) << 5) | ((v & 32'h80808080) >> 6) |
               ((v & 32'h40404040) >> 4) | ((v & 32'h04040404) >> 2);
    endfunction

    function automatic logic [31:0] inv_sub_cells(input logic [31:0] w);
        logic [31:0] v;
        logic [31:0] s;
        v = w;
        s = (~((v >> 1) | (v >> 3))) & 32'h01010101;
        v = v ^ (((~((v >> 2) | (v >> 3))) & 32'h10101010) ^ s);
        s = (~((v >> 6) | (v >> 1))) & 32'h02020202;
        v = v ^ (((~((v >> 1) | (v >> 2))) & 32'h08080808) ^ s);
        s = (~((v << 2) | (v << 1))) & 32'h80808080;
        v = v ^ (((~((v >> 1) | (v << 2))) & 32'h04040404) ^ s);
        s = (~((v << 5) | (v << 1))) & 32'h20202020;
        v = v ^ (((~((v << 4) | (v << 5))) & 32'h40404040) ^ s);
        return ((v & 32'h01010101) << 2) | ((v & 32'h04040404) << 4) |
               ((v & 32'h02020202) << 6) | ((v & 32'h20202020) >> 5) |
               ((v & 32'hC8C8C8C8) >> 2) | ((v & 32'h10101010) >> 1);
    endfunction

    function automatic t_block cipher_block(input t_opcode op, input logic [63:0] lo,
                                            input logic [63:0] hi);
        logic [31:0] row0;
        logic [31:0] row1;
        logic [31:0] row2;
        logic [31:0] row3;
        logic [31:0] tmp;
        logic [63:0] rk;
        t_block      res;
        int          nrounds;
        int          i;
        nrounds = (rounds_cfg > MAX_ROUNDS) ? MAX_ROUNDS : int'(rounds_cfg);
        row0 = lo[31:0];
        row1 = lo[63:32];
        row2 = hi[31:0];
        row3 = hi[63:32];
        if (op == OP_ENC) begin
            for (i = 0; i < nrounds; i++) begin
                rk = round_keys[i];
                row0 = sub_cells(row0) ^ rk[31:0];
                row1 = sub_cells(row1) ^ rk[63:32];
                row2 = sub_cells(row2) ^ 32'h02;
                row3 = sub_cells(row3);
                row1 = rotl32(row1, 8);
                row2 = rotl32(row2, 16);
                row3 = rotl32(row3, 24);
                // Column mixing, with the row rotation folded into the renaming.
                row1 = row1 ^ row2;
                row2 = row2 ^ row0;
                tmp  = row3 ^ row2;
                row3 = row2;
                row2 = row1;
                row1 = row0;
                row0 = tmp;
            end
        end else begin
            for (i = nrounds; i > 0; i--) begin
                rk   = round_keys[i - 1];
                tmp  = row3;
                row3 = row0 ^ tmp;
                row0 = row1;
                row1 = row2;
                row2 = tmp ^ row0;
                row1 = row1 ^ row2;
                row1 = rotl32(row1, 24);
                row2 = rotl32(row2, 16);
                row3 = rotl32(row3, 8);
                row0 = inv_sub_cells(row0 ^ rk[31:0]);
                row1 = inv_sub_cells(row1 ^ rk[63:32]);
                row2 = inv_sub_cells(row2 ^ 32'h02);
                row3 = inv_sub_cells(row3);
            end
        end
        res.lo = {row1, row0};
        res.hi = {row3, row2};
        return res;
    endfunction

    function automatic logic [63:0] rand_data();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("ERROR: %s", msg);
        end
    endtask

    // Result checker: every accepted result is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_block want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_blocks.size() == 0) begin
                report_failure($sformatf("unexpected result lo %h hi %h",
                                         o_result_low, o_result_high));
            end else begin
                want = expected_blocks.pop_front();
                blocks_checked++;
                if (o_result_low !== want.lo) begin
                    report_failure($sformatf("result_low expected %h got %h",
                                             want.lo, o_result_low));
                end
                if (o_result_high !== want.hi) begin
                    report_failure($sformatf("result_high expected %h got %h",
                                             want.hi, o_result_high));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= out_hold || ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Long output hold-off, counted here so the sender can keep pushing requests.
    always begin
        wait (hold_request != 0);
        @(posedge i_clk);
        out_hold <= 1'b1;
        repeat (hold_request) @(posedge i_clk);
        out_hold <= 1'b0;
        hold_request = 0;
    end

    task automatic send_request(input t_opcode op, input logic [5:0] kround,
                                input logic [31:0] krow0, input logic [31:0] krow1,
                                input logic [63:0] lo, input logic [63:0] hi);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_key_round    <= kround;
        i_key_row_zero <= krow0;
        i_key_row_one  <= krow1;
        i_data_low     <= lo;
        i_data_high    <= hi;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        case (op)
            OP_LOAD: begin
                if (kround < MAX_ROUNDS) begin
                    round_keys[kround] = {krow1, krow0};
                    loads_sent++;
                end else begin
                    ignored_sent++;
                end
            end
            OP_ENC: begin
                expected_blocks.push_back(cipher_block(op, lo, hi));
                enc_sent++;
            end
            OP_DEC: begin
                expected_blocks.push_back(cipher_block(op, lo, hi));
                dec_sent++;
            end
            default: ignored_sent++;
        endcase
    endtask

    task automatic send_block(input t_opcode op, input logic [63:0] lo, input logic [63:0] hi);
        send_request(op, 6'($urandom), $urandom, $urandom, lo, hi);
    endtask

    // Waits for every predicted result, then lets a key load or trailing work finish.
    task automatic drain_pipeline();
        int waited;
        i_in_valid <= 1'b0;
        waited = 0;
        while (expected_blocks.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_blocks.size() != 0) begin
            report_failure($sformatf("%0d results never arrived", expected_blocks.size()));
            expected_blocks.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_round_count(input logic [RC_W-1:0] value);
        drain_pipeline();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        rounds_cfg = value;
        settings_written++;
    endtask

    task automatic apply_reset();
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // Every round key is written before any block is processed.
    task automatic test_key_fill();
        logic [31:0] k0;
        logic [31:0] k1;
        for (int r = 0; r < MAX_ROUNDS; r++) begin
            k0 = (r == 0) ? 32'h0 : (r == MAX_ROUNDS - 1) ? 32'hFFFFFFFF : $urandom;
            k1 = (r == 0) ? 32'h0 : (r == MAX_ROUNDS - 1) ? 32'hFFFFFFFF : $urandom;
            send_request(OP_LOAD, 6'(r), k0, k1, rand_data(), rand_data());
        end
    endtask

    task automatic test_directed();
        logic [RC_W-1:0] corner_counts [5];
        corner_counts = '{6'd0, 6'd63, 6'd1, 6'd56, 6'd40};
        // Loads past the end of the key store must be dropped.
        send_request(OP_LOAD, 6'd56, '1, '1, '1, '1);
        send_request(OP_LOAD, 6'd63, '1, '1, '1, '1);
        send_block(OP_ENC, '0, '0);
        send_block(OP_ENC, '1, '1);
        send_block(OP_DEC, '0, '0);
        send_block(OP_DEC, '1, '1);
        send_request(OP_NONE, 6'd0, '1, '1, '1, '1);
        send_block(OP_ENC, rand_data(), rand_data());
        send_block(OP_DEC, rand_data(), rand_data());
        foreach (corner_counts[c]) begin
            set_round_count(corner_counts[c]);
            send_block(OP_ENC, {$urandom, $urandom}, {$urandom, $urandom});
            send_block(OP_DEC, {$urandom, $urandom}, {$urandom, $urandom});
        end
    endtask

    task automatic test_random(input int n_items, input int s_pct, input int r_pct);
        int counted;
        int pick;
        logic [5:0] kr;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int seg = 0; seg < 4; seg++) begin
            set_round_count(sweep_counts[sweep_pos % 12]);
            sweep_pos++;
            counted = 0;
            while (counted < n_items / 4) begin
                pick = $urandom_range(0, 99);
                if (pick < 72) begin
                    send_block(($urandom_range(0, 1) != 0) ? OP_ENC : OP_DEC,
                               rand_data(), rand_data());
                    counted++;
                end else if (pick < 92) begin
                    kr = 6'($urandom_range(0, 63));
                    send_request(OP_LOAD, kr, $urandom, $urandom, rand_data(), rand_data());
                    if (kr < MAX_ROUNDS) begin
                        counted++;
                    end
                end else begin
                    send_request(OP_NONE, 6'($urandom), $urandom, $urandom,
                                 rand_data(), rand_data());
                end
            end
        end
    endtask

    // The receiver stops for a long stretch while requests keep coming.
    task automatic test_output_hold();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        repeat (12) begin
            send_block(($urandom_range(0, 1) != 0) ? OP_ENC : OP_DEC, rand_data(), rand_data());
        end
        drain_pipeline();
    endtask

    initial begin
        apply_reset();
        test_key_fill();
        test_directed();
        test_random(230, 21, 63);
        test_random(230, 63, 21);
        test_random(220, 0, 0);
        test_output_hold();
        drain_pipeline();
        $display("Checked %0d blocks from %0d encrypt and %0d decrypt requests.",
                 blocks_checked, enc_sent, dec_sent);
        $display("Also sent %0d key loads and %0d ignored requests over %0d round-count settings.",
                 loads_sent, ignored_sent, settings_written);
        if (fail_count == 0) begin
            $display("** skinny128_block_cipher: PASSED **");
        end else begin
            $display("%0d failures", fail_count);
            $display("** skinny128_block_cipher: FAILED **");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout with %0d results outstanding", expected_blocks.size());
        $display("** skinny128_block_cipher: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
sv/sk128_pkg.sv
sv/sk128_round.sv
sv/skinny128_block_cipher.sv
tb/sv/skinny128_block_cipher_test.sv
